### sv/madt_pkg.sv
`default_nettype none
package madt_pkg;

	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd1;
	localparam logic [1:0] MODE_NONE  = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] RK_STORED = 2'd0;
	localparam logic [1:0] RK_DONE   = 2'd1;
	localparam logic [1:0] RK_HIT    = 2'd2;
	localparam logic [1:0] RK_MISS   = 2'd3;

	localparam logic [31:0] REC_FIRST   = 32'd44;
	localparam logic [7:0]  TYPE_LAPIC  = 8'd0;
	localparam logic [7:0]  TYPE_X2APIC = 8'd9;
	localparam logic [7:0]  LEN_LAPIC   = 8'd8;
	localparam logic [7:0]  LEN_X2APIC  = 8'd16;
	localparam logic [7:0]  PROC_X2APIC = 8'hFF;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;

	typedef struct packed {
		logic [7:0]  proc;
		logic [7:0]  apic;
		logic [31:0] flags;
	} madt_entry_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  idx;
		logic [7:0]  proc;
		logic [7:0]  apic;
		logic [31:0] flags;
		logic        enabled;
		logic        bootstrap;
		logic [6:0]  total;
		logic        last;
	} madt_res_t;

	function automatic madt_res_t make_res(input logic [1:0] kind, input logic [7:0] idx,
			input madt_entry_t e, input logic ison, input logic [6:0] total,
			input logic last);
		madt_res_t r;
		r.kind      = kind;
		r.idx       = idx;
		r.proc      = e.proc;
		r.apic      = e.apic;
		r.flags     = e.flags;
		r.enabled   = ison & e.flags[0];
		r.bootstrap = ison & (idx == 8'd0);
		r.total     = total;
		r.last      = last;
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/madt_cpu_entry_parser_unit.sv
// Processor-entry parser for an interrupt-controller description table.
// Input channel (in_valid/in_stall): one transfer per table byte (mode 0),
// first table byte restarting the parse (mode 1), "no table" (mode 2) or an
// entry query (mode 3). Output channel (out_valid/out_stall): result items,
// each with last set on the final result caused by one input transfer.
// An input transfer produces zero, one or two results: a stored entry,
// the end of parsing, or a query hit/miss.
// Throughput: one input transfer per cycle while in_stall is low; results
// leave one per cycle while out_stall is low, so the two results of one
// input leave one after the other. A result passes first through the input
// register and is then written into a four-deep result queue, from which
// it is offered on the output.
// The parse state and entry store are updated from the input register in
// a single pass; the input is stalled only when the result queue lacks
// room for two results while the input register is full.
// Reset clears the parse state, the entry count and the result queue; the
// entry store itself is not cleared, and only entries below the count are
// ever read. A stalled output holds its result; the queue then fills and
// in_stall rises.
`default_nettype none
module madt_cpu_entry_parser_unit #(
	parameter int MAX_CPUS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  mode,
	input  wire  [7:0]  data_byte,
	input  wire  [7:0]  query_index,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  entry_index,
	output logic [7:0]  cpu_id,
	output logic [7:0]  apic_id,
	output logic [31:0] entry_flags,
	output logic        enabled,
	output logic        bootstrap,
	output logic [6:0]  cpu_total,
	output logic        last
);
	import madt_pkg::*;

	localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_WALK = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	madt_entry_t        mem [MAX_CPUS];

	logic               vld_s1;
	logic [1:0]         mode_s1;
	logic [7:0]         byte_s1;
	logic [7:0]         qidx_s1;
	madt_entry_t        rd_s1;

	logic [1:0]         phase_q;
	logic [31:0]        pos_q;
	logic [31:0]        tlen_q;
	logic [31:0]        rstart_q;
	logic [7:0]         rtype_q;
	logic [7:0]         rlen_q;
	madt_entry_t        cap_q;
	logic [6:0]         stored_q;

	logic               room2;
	logic               accept;
	logic               go;
	logic [1:0]         push_n;
	madt_res_t          d0;
	madt_res_t          d1;
	madt_res_t          head;

	logic               restart;
	logic               take;
	logic [31:0]        pos_b;
	logic [31:0]        tlen_b;
	logic [31:0]        rs_b;
	logic [7:0]         typ_b;
	logic [7:0]         len_b;
	madt_entry_t        cap_b;
	logic [6:0]         st_b;

	logic [32:0]        off_w;
	logic [31:0]        off;
	logic               lt8;
	logic               hdr_end;
	logic               in_rec;
	logic               at0;
	logic               at1;
	logic [31:0]        tlen_n;
	logic [7:0]         typ_n;
	logic [7:0]         len_n;
	madt_entry_t        cap_n;
	logic [32:0]        rec_end;
	logic               fits;
	logic               end_hdr;
	logic               end_len;
	logic               end_rec;
	logic               end_tab;
	logic               rec_last;
	logic               store_rec;
	logic               do_rec;
	logic               finish;
	logic               def_store;
	logic               we;
	logic [IDX_W-1:0]   widx;
	madt_entry_t        wentry;
	madt_entry_t        rec_entry;
	logic [6:0]         st_new;
	logic               upd;
	logic               hit;

	assign go       = vld_s1 & room2;
	assign in_stall = vld_s1 & ~room2;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept | (vld_s1 & ~go);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			qidx_s1 <= query_index;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[widx] <= wentry;
		end
		if (accept) begin
			if (we && (widx == query_index[IDX_W-1:0])) begin
				rd_s1 <= wentry;
			end else begin
				rd_s1 <= mem[query_index[IDX_W-1:0]];
			end
		end
	end

	assign restart = (mode_s1 == MODE_FIRST) || (mode_s1 == MODE_NONE);
	assign take    = (mode_s1 == MODE_FIRST) ||
			((mode_s1 == MODE_BYTE) && ((phase_q == PH_HEAD) || (phase_q == PH_WALK)));

	assign pos_b  = restart ? 32'd0 : pos_q;
	assign tlen_b = restart ? 32'd0 : tlen_q;
	assign rs_b   = restart ? REC_FIRST : rstart_q;
	assign typ_b  = restart ? 8'd0 : rtype_q;
	assign len_b  = restart ? 8'd0 : rlen_q;
	assign cap_b  = restart ? madt_entry_t'('0) : cap_q;
	assign st_b   = restart ? 7'd0 : stored_q;

	assign off_w   = {1'b0, pos_b} - {1'b0, rs_b};
	assign off     = off_w[31:0];
	assign lt8     = (pos_b[31:3] == 29'd0);
	assign hdr_end = take & lt8 & (pos_b[2:0] == 3'd7);
	assign in_rec  = take & ~lt8 & ~off_w[32];
	assign at0     = in_rec & (off == 32'd0);
	assign at1     = in_rec & (off == 32'd1);

	always_comb begin
		tlen_n = tlen_b;
		if (take && lt8) begin
			case (pos_b[2:0])
				3'd4: tlen_n[7:0]   = byte_s1;
				3'd5: tlen_n[15:8]  = byte_s1;
				3'd6: tlen_n[23:16] = byte_s1;
				3'd7: tlen_n[31:24] = byte_s1;
				default: tlen_n = tlen_b;
			endcase
		end
	end

	assign typ_n = at0 ? byte_s1 : typ_b;
	assign len_n = at1 ? byte_s1 : len_b;

	always_comb begin
		cap_n = cap_b;
		if (at0) begin
			cap_n = '0;
		end else if (in_rec && (off[31:4] == 28'd0)) begin
			case (off[3:0])
				4'd2: if (typ_b == TYPE_LAPIC) cap_n.proc = byte_s1;
				4'd3: if (typ_b == TYPE_LAPIC) cap_n.apic = byte_s1;
				4'd4: begin
					if (typ_b == TYPE_LAPIC) cap_n.flags[7:0] = byte_s1;
					else cap_n.apic = byte_s1;
				end
				4'd5: if (typ_b == TYPE_LAPIC) cap_n.flags[15:8]  = byte_s1;
				4'd6: if (typ_b == TYPE_LAPIC) cap_n.flags[23:16] = byte_s1;
				4'd7: if (typ_b == TYPE_LAPIC) cap_n.flags[31:24] = byte_s1;
				4'd8: if (typ_b == TYPE_X2APIC) cap_n.flags[7:0]   = byte_s1;
				4'd9: if (typ_b == TYPE_X2APIC) cap_n.flags[15:8]  = byte_s1;
				4'd10: if (typ_b == TYPE_X2APIC) cap_n.flags[23:16] = byte_s1;
				4'd11: if (typ_b == TYPE_X2APIC) cap_n.flags[31:24] = byte_s1;
				default: cap_n = cap_b;
			endcase
		end
	end

	assign rec_end = {1'b0, rs_b} + {25'd0, len_n};
	assign fits    = (rec_end <= {1'b0, tlen_b});

	assign end_hdr  = hdr_end & (({1'b0, rs_b} + 33'd2) > {1'b0, tlen_n});
	assign end_len  = at1 & (byte_s1 < 8'd2);
	assign rec_last = in_rec & ~end_len & (off != 32'd0) &
			((off + 32'd1) == {24'd0, len_n});
	assign end_rec  = rec_last & (({1'b0, rec_end} + 34'd2) > {2'd0, tlen_b});
	assign end_tab  = take & ~lt8 & ~end_len & ~end_rec & ((pos_b + 32'd1) == tlen_b);

	assign store_rec = in_rec & ~end_len & fits &
			(((typ_b == TYPE_LAPIC) && (off == 32'd7) && (len_n >= LEN_LAPIC)) ||
			 ((typ_b == TYPE_X2APIC) && (off == 32'd15) && (len_n >= LEN_X2APIC)));
	assign do_rec    = store_rec & (st_b < 7'(MAX_CPUS));
	assign finish    = (mode_s1 == MODE_NONE) | end_hdr | end_len | end_rec | end_tab;
	assign def_store = finish & ~do_rec & (st_b == 7'd0);

	assign rec_entry.proc  = (typ_b == TYPE_LAPIC) ? cap_n.proc : PROC_X2APIC;
	assign rec_entry.apic  = cap_n.apic;
	assign rec_entry.flags = cap_n.flags;

	assign we     = go & (do_rec | def_store);
	assign widx   = st_b[IDX_W-1:0];
	assign wentry = do_rec ? rec_entry : madt_entry_t'({8'd0, 8'd0, 32'd1});
	assign st_new = st_b + 7'((do_rec | def_store) ? 1 : 0);
	assign upd    = go & (restart | take);

	assign hit = ({1'b0, stored_q} > qidx_s1) && (qidx_s1 < 8'(MAX_CPUS));

	always_comb begin
		push_n = 2'd0;
		d0     = make_res(RK_DONE, 8'd0, madt_entry_t'('0), 1'b0, st_new, 1'b1);
		d1     = d0;
		if (mode_s1 == MODE_QUERY) begin
			push_n = 2'd1;
			if (hit) begin
				d0 = make_res(RK_HIT, qidx_s1, rd_s1, 1'b1, stored_q, 1'b1);
			end else begin
				d0 = make_res(RK_MISS, qidx_s1, madt_entry_t'('0), 1'b0, stored_q, 1'b1);
			end
		end else if (do_rec || def_store) begin
			d0 = make_res(RK_STORED, {{(8-IDX_W){1'b0}}, widx}, wentry, 1'b1, st_new,
					~finish);
			push_n = finish ? 2'd2 : 2'd1;
		end else if (finish) begin
			push_n = 2'd1;
		end
		if (!go) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			tlen_q   <= '0;
			rstart_q <= REC_FIRST;
			rtype_q  <= '0;
			rlen_q   <= '0;
			cap_q    <= '0;
			stored_q <= '0;
		end else if (upd) begin
			pos_q    <= finish ? pos_b : pos_b + 32'd1;
			tlen_q   <= tlen_n;
			rstart_q <= (rec_last && !end_rec) ? rec_end[31:0] : rs_b;
			rtype_q  <= typ_n;
			rlen_q   <= len_n;
			cap_q    <= cap_n;
			stored_q <= st_new;
			if (finish) begin
				phase_q <= PH_DONE;
			end else if (hdr_end) begin
				phase_q <= PH_WALK;
			end else if (mode_s1 == MODE_FIRST) begin
				phase_q <= PH_HEAD;
			end
		end
	end

	madt_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.d0        (d0),
		.d1        (d1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign result_kind  = head.kind;
	assign entry_index  = head.idx;
	assign cpu_id       = head.proc;
	assign apic_id      = head.apic;
	assign entry_flags  = head.flags;
	assign enabled      = head.enabled;
	assign bootstrap    = head.bootstrap;
	assign cpu_total    = head.total;
	assign last         = head.last;

endmodule
`default_nettype wire

### sv/madt_rq.sv
`default_nettype none
module madt_rq (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire  [1:0]             push_n,
	input  madt_pkg::madt_res_t    d0,
	input  madt_pkg::madt_res_t    d1,
	output logic                   room2,
	output logic                   out_valid,
	input  wire                    out_stall,
	output madt_pkg::madt_res_t    head
);
	import madt_pkg::*;

	madt_res_t           buf_q [RQ_DEPTH];
	logic [RQ_AW-1:0]    wr_ptr_q;
	logic [RQ_AW-1:0]    rd_ptr_q;
	logic [RQ_AW:0]      count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign room2     = (count_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign head      = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wr_ptr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			buf_q[wr_ptr_q + RQ_AW'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + RQ_AW'(pop);
			count_q  <= count_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire
